### hw/rtl/psba_pkg.sv
package psba_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_NO_BLOCK  = 2'd3
  } psba_status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] CFG_SLOT_COUNT  = 2'd1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned BlkCntW  = 7;
  localparam int unsigned SlotCntW = 11;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned SlotIdxW = 10;
  localparam int unsigned AddrW    = 18;

  localparam logic [BlkCntW-1:0]  BLK_CNT_RST  = 7'd64;
  localparam logic [SlotCntW-1:0] SLOT_CNT_RST = 11'd1024;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SLOT_SCAN,
    S_BLK_SCAN,
    S_COMMIT,
    S_DONE
  } psba_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic         load;
    logic         take_bump;
    logic         scan_clr;
    logic         scan_run;
    logic         scan_blk;
    logic         slot_take;
    logic         blk_take;
    logic         commit;
    logic         set_status;
    psba_status_e status_code;
  } psba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic too_large;
    logic bump_ok;
    logic scan_hit;
    logic scan_end;
  } psba_stat_t;

endpackage

### hw/rtl/psba_ram.sv
module psba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/psba_ctrl.sv
module psba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  psba_pkg::psba_stat_t stat_i,
  output psba_pkg::psba_cmd_t  cmd_o
);

  psba_pkg::psba_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      psba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = psba_pkg::S_DECIDE;
        end
      end
      psba_pkg::S_DECIDE: begin
        if (stat_i.too_large) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = psba_pkg::ST_TOO_LARGE;
          state_d           = psba_pkg::S_DONE;
        end else if (stat_i.bump_ok) begin
          cmd_o.take_bump = 1'b1;
          cmd_o.scan_clr  = 1'b1;
          state_d         = psba_pkg::S_BLK_SCAN;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = psba_pkg::S_SLOT_SCAN;
        end
      end
      psba_pkg::S_SLOT_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_hit) begin
          cmd_o.slot_take = 1'b1;
          cmd_o.scan_clr  = 1'b1;
          state_d         = psba_pkg::S_BLK_SCAN;
        end else if (stat_i.scan_end) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = psba_pkg::ST_NO_SLOT;
          state_d           = psba_pkg::S_DONE;
        end
      end
      psba_pkg::S_BLK_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_blk = 1'b1;
        if (stat_i.scan_hit) begin
          cmd_o.blk_take = 1'b1;
          state_d        = psba_pkg::S_COMMIT;
        end else if (stat_i.scan_end) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = psba_pkg::ST_NO_BLOCK;
          state_d           = psba_pkg::S_DONE;
        end
      end
      psba_pkg::S_COMMIT: begin
        cmd_o.commit      = 1'b1;
        cmd_o.set_status  = 1'b1;
        cmd_o.status_code = psba_pkg::ST_OK;
        state_d           = psba_pkg::S_DONE;
      end
      psba_pkg::S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = psba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/psba_dp.sv
module psba_dp #(
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned MAX_BLOCKS  = 64,
  parameter int unsigned MAX_SLOTS   = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [psba_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [psba_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [psba_pkg::SizeW-1:0]          request_size_i,
  input  psba_pkg::psba_cmd_t                 cmd_i,
  output psba_pkg::psba_stat_t                stat_o,
  output logic [1:0]                          status_o,
  output logic [psba_pkg::SlotIdxW-1:0]       slot_index_o,
  output logic [psba_pkg::AddrW-1:0]          address_o
);

  localparam int unsigned SlotCap = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;
  localparam int unsigned BlkCap  = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
  localparam int unsigned SaW     = (SlotCap > 1) ? $clog2(SlotCap) : 1;
  localparam int unsigned BaW     = (BlkCap > 1) ? $clog2(BlkCap) : 1;
  localparam int unsigned FillW   = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned SW      = psba_pkg::SlotCntW;
  localparam int unsigned BW      = psba_pkg::BlkCntW;
  localparam logic [SW-1:0] SlotCapW = SW'(SlotCap);
  localparam logic [BW-1:0] BlkCapW  = BW'(BlkCap);
  localparam logic [17:0]   BlkBytes18 = 18'(BLOCK_BYTES);

  logic [BW-1:0]    blk_cnt_q;
  logic [SW-1:0]    slot_cnt_q;
  logic [SW-1:0]    next_slot_q;
  logic [BW-1:0]    hw_q;
  logic [SW-1:0]    scan_q;
  logic [SW-1:0]    rd_idx_q;
  logic             rd_vld_q;
  logic [psba_pkg::SizeW-1:0] size_q;
  logic [SW-1:0]    slot_q;
  logic [BW-1:0]    blk_q;
  logic [FillW-1:0] fill_q;
  psba_pkg::psba_status_e status_q;
  logic [psba_pkg::AddrW-1:0] addr_q;

  logic [SW-1:0]    slots_eff;
  logic [BW-1:0]    blocks_eff;
  logic [SW-1:0]    limit;
  logic             issue;
  logic             hit;
  logic             slot_rdata;
  logic [FillW-1:0] blk_rdata;
  logic [FillW-1:0] blk_data;
  logic [17:0]      fit_sum;
  logic [17:0]      new_fill;
  logic [31:0]      addr_full;
  logic             slot_we;
  logic [SW-1:0]    slot_waddr;

  // Clamp the configured counts to the built capacity
  assign slots_eff  = (slot_cnt_q > SlotCapW) ? SlotCapW : slot_cnt_q;
  assign blocks_eff = (blk_cnt_q > BlkCapW) ? BlkCapW : blk_cnt_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q  <= psba_pkg::BLK_CNT_RST;
      slot_cnt_q <= psba_pkg::SLOT_CNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psba_pkg::CFG_BLOCK_COUNT: blk_cnt_q  <= cfg_data_i[BW-1:0];
        psba_pkg::CFG_SLOT_COUNT:  slot_cnt_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Scan: issue one read per cycle, check the entry read last cycle
  assign limit    = cmd_i.scan_blk ? SW'(blocks_eff) : slots_eff;
  assign blk_data = (rd_idx_q[BW-1:0] < hw_q) ? blk_rdata : '0;
  assign fit_sum  = 18'(blk_data) + 18'(size_q);
  assign hit      = rd_vld_q && (cmd_i.scan_blk ?
                    ((blk_data == '0) || (fit_sum <= BlkBytes18)) : !slot_rdata);
  assign issue    = cmd_i.scan_run && !hit && (scan_q < limit);

  assign stat_o.too_large = ({1'b0, size_q} > 17'(BLOCK_BYTES));
  assign stat_o.bump_ok   = (next_slot_q < slots_eff);
  assign stat_o.scan_hit  = hit;
  assign stat_o.scan_end  = !hit && (scan_q >= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
  end

  // Bump counter and written-block high-water mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      hw_q        <= '0;
    end else begin
      if (cmd_i.take_bump) begin
        next_slot_q <= next_slot_q + 1'b1;
      end
      if (cmd_i.commit && (blk_q == hw_q)) begin
        hw_q <= hw_q + 1'b1;
      end
    end
  end

  // Item and result registers
  assign new_fill  = 18'(fill_q) + 18'(size_q);
  assign addr_full = 32'(blk_q) * 32'(BLOCK_BYTES) + 32'(fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q <= request_size_i;
      slot_q <= '0;
      addr_q <= '0;
    end
    if (cmd_i.take_bump) begin
      slot_q <= next_slot_q;
    end
    if (cmd_i.slot_take) begin
      slot_q <= rd_idx_q;
    end
    if (cmd_i.blk_take) begin
      blk_q  <= rd_idx_q[BW-1:0];
      fill_q <= blk_data;
    end
    if (cmd_i.commit) begin
      addr_q <= addr_full[psba_pkg::AddrW-1:0];
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
  end

  // Slot used bits: cleared when a slot leaves the bump counter, set on success
  assign slot_we    = cmd_i.take_bump || cmd_i.commit;
  assign slot_waddr = cmd_i.take_bump ? next_slot_q : slot_q;

  psba_ram #(
    .Width(1),
    .Depth(SlotCap)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr[SaW-1:0]),
    .wdata_i(cmd_i.commit),
    .raddr_i(scan_q[SaW-1:0]),
    .rdata_o(slot_rdata)
  );

  // Block fill levels; blocks at or above the high-water mark read as empty
  psba_ram #(
    .Width(FillW),
    .Depth(BlkCap)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(blk_q[BaW-1:0]),
    .wdata_i(new_fill[FillW-1:0]),
    .raddr_i(scan_q[BaW-1:0]),
    .rdata_o(blk_rdata)
  );

  assign status_o     = status_q;
  assign slot_index_o = slot_q[psba_pkg::SlotIdxW-1:0];
  assign address_o    = addr_q;

endmodule

### hw/rtl/pointer_slot_block_allocator.sv
// Steps: accept, a decide state, slot scan (lowest free slot first, only once the bump
//   counter is spent), block scan (first fitting block), a commit state, then the result is
//   held until taken. Oversized requests go from the decide state straight to the result.
// One item at a time: a new request is taken only once the last result is taken. The slot
//   and block RAMs are walked one entry per cycle.
// Reset: block_count 64, slot_count 1024, counters cleared; no RAM clearing pass.
module pointer_slot_block_allocator #(
  parameter int unsigned BLOCK_BYTES = 4096,
  parameter int unsigned MAX_BLOCKS  = 64,
  parameter int unsigned MAX_SLOTS   = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psba_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psba_pkg::SizeW-1:0]    request_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [psba_pkg::SlotIdxW-1:0] slot_index_o,
  output logic [psba_pkg::AddrW-1:0]    address_o
);

  psba_pkg::psba_cmd_t  cmd;
  psba_pkg::psba_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  psba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psba_dp #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .request_size_i(request_size_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .address_o     (address_o)
  );

endmodule

### hw/rtl/psba_checker.sv
module psba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [psba_pkg::SlotIdxW-1:0] slot_index_o,
  input logic [psba_pkg::AddrW-1:0]    address_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_index_o) && $stable(address_o))
    else $error("result changed while stalled");

  // Take no item while a result waits
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item accepted while result pending");

  // An accepted item keeps the block busy and has no result in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block not busy after accepting an item");

  // Drop slot and address on early rejects
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == psba_pkg::ST_TOO_LARGE || status_o == psba_pkg::ST_NO_SLOT)
      |-> slot_index_o == '0 && address_o == '0)
    else $error("rejected result carries slot or address");

  // No address without a block
  a_noblk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == psba_pkg::ST_NO_BLOCK |-> address_o == '0)
    else $error("no-block result carries an address");

endmodule

bind pointer_slot_block_allocator psba_checker u_psba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .slot_index_o(slot_index_o),
  .address_o   (address_o)
);

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned MAX_BLOCKS  = 64;
  localparam int unsigned MAX_SLOTS   = 1024;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned LONG_HOLD   = 600;

  localparam int unsigned CfgIdxW  = psba_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = psba_pkg::CfgDataW;
  localparam int unsigned BlkCntW  = psba_pkg::BlkCntW;
  localparam int unsigned SlotCntW = psba_pkg::SlotCntW;
  localparam int unsigned SizeW    = psba_pkg::SizeW;
  localparam int unsigned SlotIdxW = psba_pkg::SlotIdxW;
  localparam int unsigned AddrW    = psba_pkg::AddrW;

  // Register indexes that map to no register
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_TOGGLE
  } rx_mode_e;

  typedef struct {
    psba_pkg::psba_status_e status;
    logic [SlotIdxW-1:0]    slot_index;
    logic [AddrW-1:0]       address;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SizeW-1:0]    request_size_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic [AddrW-1:0]    address_o;

  // Allocator state as predicted
  logic [BlkCntW-1:0]  blk_cnt_q;
  logic [SlotCntW-1:0] slot_cnt_q;
  logic [SlotCntW-1:0] next_slot_q;
  bit                  slot_used_q [MAX_SLOTS];
  int unsigned         block_fill_q [MAX_BLOCKS];

  logic [SizeW-1:0]    pending_sizes [$];
  alloc_result_t       expected_allocs [$];
  int                  items_queued;
  int                  results_seen;
  int                  error_count;
  int unsigned         cycle_count;
  logic                req_taken;

  int                  burst_left;
  int                  gap_left;
  rx_mode_e            rx_mode;
  int                  rx_mode_left;
  int                  rx_hold_left;
  bit                  long_hold_done;

  pointer_slot_block_allocator #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .request_size_i (request_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .address_o      (address_o)
  );

  always #5 clk_i = ~clk_i;

  // Reject oversized sizes, else take a slot, then the first block that fits, and bump its fill
  function automatic alloc_result_t predict_alloc(input logic [SizeW-1:0] size);
    alloc_result_t res;
    int unsigned   slots;
    int unsigned   blocks;
    int unsigned   slot;
    int unsigned   blk;
    int unsigned   i;
    bit            found;
    res.status     = psba_pkg::ST_OK;
    res.slot_index = '0;
    res.address    = '0;
    slots  = (slot_cnt_q > MAX_SLOTS) ? MAX_SLOTS : slot_cnt_q;
    blocks = (blk_cnt_q > MAX_BLOCKS) ? MAX_BLOCKS : blk_cnt_q;
    slot   = 0;
    found  = 1'b0;
    if (size > BLOCK_BYTES) begin
      res.status = psba_pkg::ST_TOO_LARGE;
      return res;
    end
    // Bump counter first, then the lowest clear slot
    if (next_slot_q < slots) begin
      slot        = next_slot_q;
      next_slot_q = next_slot_q + 1'b1;
      found       = 1'b1;
    end else begin
      for (i = 0; i < slots; i++) begin
        if (!slot_used_q[i]) begin
          slot  = i;
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      res.status = psba_pkg::ST_NO_SLOT;
      return res;
    end
    res.slot_index = SlotIdxW'(slot);
    for (blk = 0; blk < blocks; blk++) begin
      if (block_fill_q[blk] == 0 || block_fill_q[blk] + size <= BLOCK_BYTES) break;
    end
    if (blk >= blocks) begin
      res.status = psba_pkg::ST_NO_BLOCK;
      return res;
    end
    res.address        = AddrW'(blk * BLOCK_BYTES + block_fill_q[blk]);
    block_fill_q[blk] += size;
    slot_used_q[slot]  = 1'b1;
    return res;
  endfunction

  // Mostly small requests so the heap lasts; some boundary and oversized ones
  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return SizeW'($urandom_range(0, 63));
    else if (r < 62) return '0;
    else if (r < 72) return SizeW'($urandom_range(64, BLOCK_BYTES - 1));
    else if (r < 75) return SizeW'(BLOCK_BYTES);
    else if (r < 78) return SizeW'($urandom_range(BLOCK_BYTES - 1, BLOCK_BYTES + 1));
    else if (r < 90) return SizeW'($urandom_range(BLOCK_BYTES + 1, 65535));
    else return SizeW'($urandom_range(0, 255));
  endfunction

  task automatic queue_request(input logic [SizeW-1:0] size);
    pending_sizes.push_back(size);
    items_queued++;
  endtask

  // Write one register; the block is idle whenever this is called
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      psba_pkg::CFG_BLOCK_COUNT: blk_cnt_q  = data[BlkCntW-1:0];
      psba_pkg::CFG_SLOT_COUNT:  slot_cnt_q = data[SlotCntW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every queued item has its result, then let the block settle
  task automatic drain();
    while (results_seen != items_queued) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Sender: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_taken) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (pending_sizes.size() > 0) begin
      in_valid_i     <= 1'b1;
      request_size_i <= pending_sizes.pop_front();
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       gap_left = 0;
          1:       gap_left = $urandom_range(20, 120);
          default: gap_left = $urandom_range(1, 8);
        endcase
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: stall pattern of its own plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done = 1'b1;
      rx_hold_left   = LONG_HOLD;
      out_ready_i   <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // Predict on every accepted request
  always @(posedge clk_i) begin
    req_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) expected_allocs.push_back(predict_alloc(request_size_i));
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    alloc_result_t exp_res;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      results_seen++;
      if (expected_allocs.size() == 0) begin
        $error("result with no request pending: status %0d slot_index %0d address %0d",
               status_o, slot_index_o, address_o);
        error_count++;
      end else begin
        exp_res = expected_allocs.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          error_count++;
        end
        if (slot_index_o !== exp_res.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_res.slot_index, slot_index_o);
          error_count++;
        end
        if (address_o !== exp_res.address) begin
          $error("address: expected %0d, got %0d", exp_res.address, address_o);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int                  p;
    int                  n;
    logic [BlkCntW-1:0]  bc;
    logic [SlotCntW-1:0] sc;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    request_size_i = '0;
    out_ready_i    = 1'b0;
    req_taken      = 1'b0;
    blk_cnt_q      = psba_pkg::BLK_CNT_RST;
    slot_cnt_q     = psba_pkg::SLOT_CNT_RST;
    next_slot_q    = '0;
    items_queued   = 0;
    results_seen   = 0;
    error_count    = 0;
    cycle_count    = 0;
    burst_left     = 0;
    gap_left       = 0;
    rx_mode        = RX_ALWAYS;
    rx_mode_left   = 0;
    rx_hold_left   = 0;
    long_hold_done = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero size, exact block, oversized, fills that just fit
    queue_request(16'd0);
    queue_request(16'd1);
    queue_request(16'd4096);
    queue_request(16'd4097);
    queue_request(16'hFFFF);
    queue_request(16'd4095);
    queue_request(16'd2048);
    queue_request(16'd2048);
    queue_request(16'd0);
    drain();

    // Only full blocks in range: no block fits, yet zero size still does
    write_reg(psba_pkg::CFG_BLOCK_COUNT, 11'h782);
    queue_request(16'd1);
    queue_request(16'd0);
    drain();

    // No blocks at all
    write_reg(psba_pkg::CFG_BLOCK_COUNT, 11'd0);
    queue_request(16'd5);
    drain();

    // No slots at all; oversized still wins
    write_reg(psba_pkg::CFG_SLOT_COUNT, 11'd0);
    queue_request(16'd7);
    queue_request(16'hFFFF);
    drain();

    // Bump counter spent: search reuses the slot left clear, then runs dry
    write_reg(psba_pkg::CFG_SLOT_COUNT, 11'd8);
    write_reg(psba_pkg::CFG_BLOCK_COUNT, 11'd127);
    queue_request(16'd0);
    queue_request(16'd0);
    drain();

    // Counts above the maximum, plus writes to unmapped indexes
    write_reg(psba_pkg::CFG_SLOT_COUNT, 11'd2047);
    write_reg(psba_pkg::CFG_BLOCK_COUNT, 11'd65);
    write_reg(CFG_SPARE_A, 11'h555);
    write_reg(CFG_SPARE_B, 11'h2AA);
    queue_request(16'd4096);
    queue_request(16'd100);
    drain();

    // Random phases, each under its own settings
    for (p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0:       bc = 7'd0;
        1:       bc = 7'd127;
        2:       bc = 7'd65;
        3:       bc = 7'($urandom_range(1, 4));
        4, 5:    bc = 7'd64;
        default: bc = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       sc = 11'd0;
        1:       sc = 11'd2047;
        2:       sc = 11'($urandom_range(1, 16));
        3:       sc = 11'($urandom_range(1, 1024));
        4:       sc = 11'd1025;
        default: sc = 11'd1024;
      endcase
      write_reg(psba_pkg::CFG_BLOCK_COUNT, {4'($urandom), bc});
      write_reg(psba_pkg::CFG_SLOT_COUNT, sc);
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 11'($urandom));
      end
      for (n = 0; n < 103; n++) queue_request(pick_size());
      drain();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/psba_pkg.sv
hw/rtl/psba_ram.sv
hw/rtl/psba_ctrl.sv
hw/rtl/psba_dp.sv
hw/rtl/pointer_slot_block_allocator.sv
hw/rtl/psba_checker.sv
dv/testbench.sv
